@@ hdl/domino_tiling_count_assert.svh @@
// assertion macros used by the checker file
`ifndef DOMINO_TILING_COUNT_ASSERT_SVH
`define DOMINO_TILING_COUNT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define DTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("domino_tiling_count: assertion failed");

// next-cycle implication, off while reset is high
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("domino_tiling_count: assertion failed");

// next-cycle implication that also checks the reset cycle itself
`define DTC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("domino_tiling_count: reset assertion failed");

`endif

@@ hdl/dtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtc_pkg;

   // fixed field widths
   localparam int DIM_W    = 4;
   localparam int COUNT_W  = 64;
   localparam int RESULT_W = 56;

   // widest profile the fit check handles
   localparam int PROFILE_LIMIT = 12;

   // defaults and limits
   localparam int MAX_COLS_DEF = 12;
   localparam logic [DIM_W-1:0] MAX_ROWS_LIM = 4'd12;

   // row store port control
   typedef struct packed {
      logic wr_en;
      logic wr_bank;
      logic rd_bank;
   } store_ctl_type;

   // shared adder control
   typedef struct packed {
      logic add_en;
      logic clear;
      logic use_data;
   } acc_ctl_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

   // true when every run of free cells among the low w bits is even
   function automatic logic fits_profile(logic [PROFILE_LIMIT-1:0] m, logic [DIM_W-1:0] w);
      logic run_odd;
      logic ok;
      run_odd = 1'b0;
      ok      = 1'b1;
      for (int b = 0; b < PROFILE_LIMIT; b++) begin
         if (DIM_W'(b) < w) begin
            if (!m[b]) begin
               run_odd = ~run_odd;
            end else begin
               if (run_odd) ok = 1'b0;
               run_odd = 1'b0;
            end
         end
      end
      return ok && !run_odd;
   endfunction

endpackage
`default_nettype wire

@@ hdl/dtc_row_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtc_row_store #(
   parameter int ADDR_W = 12
) (
   input  wire logic                        clock,
   input  wire dtc_pkg::store_ctl_type      ctl,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [dtc_pkg::COUNT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [dtc_pkg::COUNT_W-1:0] rd_data
);
   import dtc_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   logic [COUNT_W-1:0] even_mem [DEPTH];
   logic [COUNT_W-1:0] odd_mem  [DEPTH];
   logic [COUNT_W-1:0] rd_even_ff;
   logic [COUNT_W-1:0] rd_odd_ff;
   logic               rd_bank_ff;

   // at most one write, to the selected bank, and one registered read per bank each cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en && !ctl.wr_bank) even_mem[wr_addr] <= wr_data;
      if (ctl.wr_en && ctl.wr_bank) odd_mem[wr_addr] <= wr_data;
      rd_even_ff <= even_mem[rd_addr];
      rd_odd_ff  <= odd_mem[rd_addr];
      rd_bank_ff <= ctl.rd_bank;
   end

   assign rd_data = rd_bank_ff ? rd_odd_ff : rd_even_ff;

endmodule
`default_nettype wire

@@ hdl/dtc_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtc_accum (
   input  wire logic                        clock,
   input  wire dtc_pkg::acc_ctl_type        ctl,
   input  wire logic [dtc_pkg::COUNT_W-1:0] operand,
   output logic      [dtc_pkg::COUNT_W-1:0] sum,
   output logic      [dtc_pkg::COUNT_W-1:0] acc
);
   import dtc_pkg::*;

   logic [COUNT_W-1:0] acc_ff;
   logic [COUNT_W-1:0] base;
   logic [COUNT_W-1:0] addend;

   // shared 64-bit adder, restarted at the first term of each profile
   always_comb begin
      base   = ctl.clear ? '0 : acc_ff;
      addend = ctl.use_data ? operand : '0;
      sum    = base + addend;
   end

   always_ff @(posedge clock) begin
      if (ctl.add_en) acc_ff <= sum;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

@@ hdl/dtc_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtc_seq #(
   parameter int MAX_COLS = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [dtc_pkg::DIM_W-1:0]    start_height,
   input  wire logic [dtc_pkg::DIM_W-1:0]    start_width,
   input  wire logic                         out_free,
   output dtc_pkg::seq_status_type           status,
   output logic      [dtc_pkg::RESULT_W-1:0] result,
   output dtc_pkg::store_ctl_type            store_ctl,
   output logic      [MAX_COLS-1:0]          store_wr_addr,
   output logic      [dtc_pkg::COUNT_W-1:0]  store_wr_data,
   output logic      [MAX_COLS-1:0]          store_rd_addr,
   output dtc_pkg::acc_ctl_type              acc_ctl,
   input  wire logic [dtc_pkg::COUNT_W-1:0]  acc_sum,
   input  wire logic [dtc_pkg::COUNT_W-1:0]  acc_value
);
   import dtc_pkg::*;

   localparam int ADDR_W = MAX_COLS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INIT   = 5'b00010,
      ST_ROW    = 5'b00100,
      ST_GAP    = 5'b01000,
      ST_FINISH = 5'b10000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [DIM_W-1:0]  h_ff, h_in;
   logic [DIM_W-1:0]  w_ff, w_in;
   logic              bad_ff, bad_in;
   logic              single_ff, single_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic              first_ff, first_in;

   // read stage tags
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_fit_ff, rd_fit_in;
   logic              rd_first_ff, rd_first_in;
   logic              rd_last_ff, rd_last_in;
   logic [ADDR_W-1:0] rd_q_ff, rd_q_in;

   logic [ADDR_W-1:0] full;
   logic [ADDR_W-1:0] avail;
   logic [ADDR_W-1:0] q_plus;
   logic              last_row;
   logic              init_fit;
   logic              start_bad;

   // mask of the active profile bits
   always_comb begin
      for (int i = 0; i < ADDR_W; i++) begin
         full[i] = (DIM_W'(i) < w_ff);
      end
   end

   assign avail     = ~q_ff & full;
   assign q_plus    = q_ff + ADDR_W'(1);
   assign last_row  = (row_ff == (h_ff - DIM_W'(1)));
   assign init_fit  = fits_profile(PROFILE_LIMIT'(p_ff), w_ff);
   assign start_bad = (start_height == '0) || (start_height > MAX_ROWS_LIM) ||
                      (start_width == '0) || (start_width > DIM_W'(MAX_COLS));

   // sequencer: fill row 0, then walk rows over (q, subset p) pairs
   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      w_in        = w_ff;
      bad_in      = bad_ff;
      single_in   = single_ff;
      row_in      = row_ff;
      q_in        = q_ff;
      p_in        = p_ff;
      first_in    = first_ff;
      rd_vld_in   = 1'b0;
      rd_fit_in   = 1'b0;
      rd_first_in = first_ff;
      rd_last_in  = (p_ff == '0);
      rd_q_in     = q_ff;
      store_ctl.rd_bank = ~row_ff[0];
      store_rd_addr     = p_ff;

      // stage two writes the finished sum of a profile
      store_ctl.wr_en   = rd_vld_ff && rd_last_ff && !last_row;
      store_ctl.wr_bank = row_ff[0];
      store_wr_addr     = rd_q_ff;
      store_wr_data     = acc_sum;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               h_in      = start_height;
               w_in      = start_width;
               bad_in    = start_bad;
               single_in = (start_height == DIM_W'(1));
               p_in      = '0;
               if (start_bad || start_height == DIM_W'(1)) state_in = ST_FINISH;
               else state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            store_ctl.wr_en   = 1'b1;
            store_ctl.wr_bank = 1'b0;
            store_wr_addr     = p_ff;
            store_wr_data     = init_fit ? COUNT_W'(1) : '0;
            p_in              = p_ff + ADDR_W'(1);
            if (p_ff == full) begin
               state_in = ST_ROW;
               row_in   = DIM_W'(1);
               q_in     = '0;
               p_in     = full;
               first_in = 1'b1;
            end
         end
         ST_ROW: begin
            rd_vld_in = 1'b1;
            rd_fit_in = fits_profile(PROFILE_LIMIT'(p_ff | q_ff), w_ff);
            if (p_ff != '0) begin
               p_in     = (p_ff - ADDR_W'(1)) & avail;
               first_in = 1'b0;
            end else if (last_row || q_ff == full) begin
               state_in = ST_GAP;
            end else begin
               q_in     = q_plus;
               p_in     = ~q_plus & full;
               first_in = 1'b1;
            end
         end
         ST_GAP: begin
            if (last_row) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ROW;
               row_in   = row_ff + DIM_W'(1);
               q_in     = '0;
               p_in     = full;
               first_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // accumulate the store data in the cycle after its read is issued
   assign acc_ctl.add_en   = rd_vld_ff;
   assign acc_ctl.clear    = rd_first_ff;
   assign acc_ctl.use_data = rd_fit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      w_ff        <= w_in;
      bad_ff      <= bad_in;
      single_ff   <= single_in;
      row_ff      <= row_in;
      q_ff        <= q_in;
      p_ff        <= p_in;
      first_ff    <= first_in;
      rd_fit_ff   <= rd_fit_in;
      rd_first_ff <= rd_first_in;
      rd_last_ff  <= rd_last_in;
      rd_q_ff     <= rd_q_in;
   end

   // result select: bad size, single row, or the final sum
   always_comb begin
      if (bad_ff) result = '0;
      else if (single_ff) result = w_ff[0] ? '0 : RESULT_W'(1);
      else result = acc_value[RESULT_W-1:0];
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_FINISH);

endmodule
`default_nettype wire

@@ hdl/domino_tiling_count.sv @@
// domino tiling counter, row-profile count over a shared 64-bit adder.
// each item fills the first row, then makes one memory read and one add per profile pair;
// a single row or a bad size goes straight to the result.
// a new item is taken only once the sequencer is idle again after the last one.
// the next item is taken while a result waits in the output register.
// reset: synchronous, active high; the row stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module domino_tiling_count #(
   parameter int MAX_COLS = dtc_pkg::MAX_COLS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [dtc_pkg::DIM_W-1:0]    req_grid_height,
   input  wire logic [dtc_pkg::DIM_W-1:0]    req_grid_width,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [dtc_pkg::RESULT_W-1:0] rsp_tiling_count
);
   import dtc_pkg::*;

   seq_status_type    status;
   store_ctl_type     store_ctl;
   acc_ctl_type       acc_ctl;
   logic [RESULT_W-1:0] result;
   logic [MAX_COLS-1:0] store_wr_addr;
   logic [MAX_COLS-1:0] store_rd_addr;
   logic [COUNT_W-1:0]  store_wr_data;
   logic [COUNT_W-1:0]  store_rd_data;
   logic [COUNT_W-1:0]  acc_sum;
   logic [COUNT_W-1:0]  acc_value;
   logic                start;
   logic                out_free;
   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_count_ff;

   assign req_ready = status.idle;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   dtc_seq #(.MAX_COLS(MAX_COLS)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .start_height  (req_grid_height),
      .start_width   (req_grid_width),
      .out_free      (out_free),
      .status        (status),
      .result        (result),
      .store_ctl     (store_ctl),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .acc_ctl       (acc_ctl),
      .acc_sum       (acc_sum),
      .acc_value     (acc_value)
   );

   dtc_row_store #(.ADDR_W(MAX_COLS)) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   dtc_accum u_accum (
      .clock   (clock),
      .ctl     (acc_ctl),
      .operand (store_rd_data),
      .sum     (acc_sum),
      .acc     (acc_value)
   );

   // output register for the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done && out_free) rsp_count_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tiling_count = rsp_count_ff;

endmodule
`default_nettype wire

@@ hdl/dtc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "domino_tiling_count_assert.svh"
module dtc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [dtc_pkg::RESULT_W-1:0] rsp_tiling_count
);

   // a waiting result beat holds its value
   `DTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tiling_count))

   // an accepted request beat makes the block busy
   `DTC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a new result only appears out of a busy cycle
   `DTC_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // reset leaves the block ready with no result pending
   `DTC_ASSERT_ALWAYS_NEXT(a_reset_state, clock, reset, !rsp_valid && req_ready)

endmodule

bind domino_tiling_count dtc_checker u_checker (.*);
`default_nettype wire
